FILE: hdl/egcd_pkg.sv
`timescale 1ns / 1ps
package egcd_pkg;

  // Handshake between the sequencer and the divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

FILE: hdl/egcd_if.sv
`timescale 1ns / 1ps
// Operand channel
interface egcd_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] x_value;
  logic signed [W-1:0] y_value;
  modport source (output valid, x_value, y_value, input ready);
  modport sink   (input valid, x_value, y_value, output ready);
endinterface

// Result channel
interface egcd_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] coef_x;
  logic signed [W-1:0] coef_y;
  logic        [W-2:0] gcd_value;
  logic                bad_input;
  modport source (output valid, coef_x, coef_y, gcd_value, bad_input, input ready);
  modport sink   (input valid, coef_x, coef_y, gcd_value, bad_input, output ready);
endinterface

FILE: hdl/egcd_divider.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle
module egcd_divider #(
  parameter int W = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [W-1:0]               dividend_i,
  input  logic [W-1:0]               divisor_i,
  output egcd_pkg::div_status_t      status_o,
  output logic [W-1:0]               quot_o,
  output logic [W-1:0]               rem_o
);
  import egcd_pkg::*;

  localparam int CW = $clog2(W);

  logic [W-1:0]  rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W-1:0]  trial;

  assign trial = {rem_q[W-2:0], quo_q[W-1]};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CW'(W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in next dividend bit, subtract when it fits
      if (trial >= dvs_q) begin
        rem_d = trial - dvs_q;
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quo_q;
  assign rem_o         = rem_q;

endmodule

FILE: hdl/signed_extended_gcd.sv
`timescale 1ns / 1ps
// Signed extended gcd: for operands x, y returns d = gcd > 0 and a, b with
// a*x + b*y = d (coefficients modulo 2^WIDTH).
// Channels: in_i carries x_value/y_value, out_o carries coef_x, coef_y,
// gcd_value and bad_input; both are valid/ready, item moves when both high.
// One item at a time: in_i.ready is high only while the block is idle.
// y = 0 or an operand equal to the most negative value gives bad_input = 1
// with all other fields zero, valid in the cycle after acceptance.
// Otherwise each Euclidean division step runs start, the bit-serial divider,
// sign fixup, S_MULS and S_MULT on the one shared multiplier and one
// coefficient update (S_UPD); there are up to ~46 steps at WIDTH = 32
// before a valid result.
// The result sits in the output register until taken; a stalled receiver
// holds the block in its output state, not ready for a new item.
// Reset returns to idle, no item in flight.
module signed_extended_gcd #(
  parameter int WIDTH = 32
) (
  input logic         clk_i,
  input logic         rst_ni,
  egcd_in_if.sink     in_i,
  egcd_out_if.source  out_o
);
  import egcd_pkg::*;

  localparam int W = WIDTH;
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_MULS  = 3'd3;
  localparam logic [2:0] S_MULT  = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

  logic [2:0]   state_q, state_d;
  logic [W-1:0] x_q, x_d, y_q, y_d, r_q, r_d, p_q, p_d, prod_q, prod_d;
  logic [W-1:0] s1_q, s1_d, t1_q, t1_d, s2_q, s2_d, t2_q, t2_d;
  logic [W-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [W-2:0] g_q, g_d;
  logic         bad_q, bad_d;

  div_status_t  div_st;
  logic         div_start;
  logic [W-1:0] quot, rem, x_mag, y_mag, q_signed, mul_b, mul_res;
  logic         x_neg, y_neg;

  assign x_neg = x_q[W-1];
  assign y_neg = y_q[W-1];
  assign x_mag = x_neg ? (~x_q + 1'b1) : x_q;
  assign y_mag = y_neg ? (~y_q + 1'b1) : y_q;
  assign div_start = (state_q == S_DIV);

  egcd_divider #(.W(W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (x_mag),
    .divisor_i  (y_mag),
    .status_o   (div_st),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // truncated quotient with the sign of x*y
  assign q_signed = (x_neg ^ y_neg) ? (~quot + 1'b1) : quot;

  // shared multiplier, low W bits only
  assign mul_b   = (state_q == S_MULS) ? s2_q : t2_q;
  assign mul_res = W'(p_q * mul_b);

  always_comb begin
    state_d = state_q;
    x_d = x_q;   y_d = y_q;   r_d = r_q;   p_d = p_q;   prod_d = prod_q;
    s1_d = s1_q; t1_d = t1_q; s2_d = s2_q; t2_d = t2_q;
    cx_d = cx_q; cy_d = cy_q; g_d = g_q;   bad_d = bad_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          x_d  = in_i.x_value;
          y_d  = in_i.y_value;
          s1_d = W'(1);
          t1_d = '0;
          s2_d = '0;
          t2_d = W'(1);
          if (in_i.y_value == '0 || in_i.x_value == MIN_VAL
              || in_i.y_value == MIN_VAL) begin
            cx_d    = '0;
            cy_d    = '0;
            g_d     = '0;
            bad_d   = 1'b1;
            state_d = S_OUT;
          end else begin
            bad_d   = 1'b0;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: state_d = S_WAIT;
      S_WAIT: begin
        if (div_st.done) begin
          // Euclidean fixup: remainder made non-negative
          if (x_neg && rem != '0) begin
            r_d = y_mag - rem;
            p_d = y_neg ? q_signed + 1'b1 : q_signed - 1'b1;
          end else begin
            r_d = rem;
            p_d = q_signed;
          end
          if (x_neg ? (rem == '0) : (rem == '0)) begin
            // chain ends: d = |y|, scale by sign(y)
            g_d     = y_mag[W-2:0];
            cx_d    = y_neg ? (~s2_q + 1'b1) : s2_q;
            cy_d    = y_neg ? (~t2_q + 1'b1) : t2_q;
            state_d = S_OUT;
          end else begin
            state_d = S_MULS;
          end
        end
      end
      S_MULS: begin
        prod_d  = mul_res;
        state_d = S_MULT;
      end
      S_MULT: begin
        s1_d    = s2_q;
        s2_d    = s1_q - prod_q;
        prod_d  = mul_res;
        state_d = S_UPD;
      end
      S_UPD: begin
        t1_d    = t2_q;
        t2_d    = t1_q - prod_q;
        x_d     = y_q;
        y_d     = r_q;
        state_d = S_DIV;
      end
      S_OUT: begin
        if (out_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;   y_q <= y_d;   r_q <= r_d;   p_q <= p_d;   prod_q <= prod_d;
    s1_q <= s1_d; t1_q <= t1_d; s2_q <= s2_d; t2_q <= t2_d;
    cx_q <= cx_d; cy_q <= cy_d; g_q <= g_d;   bad_q <= bad_d;
  end

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = (state_q == S_OUT);
  assign out_o.coef_x    = cx_q;
  assign out_o.coef_y    = cy_q;
  assign out_o.gcd_value = g_q;
  assign out_o.bad_input = bad_q;

endmodule

FILE: hdl/egcd_checker.sv
`timescale 1ns / 1ps
module egcd_checker #(
  parameter int W = 32
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_ready_i,
  input logic         out_valid_i,
  input logic         out_ready_i,
  input logic [W-1:0] coef_x_i,
  input logic [W-1:0] coef_y_i,
  input logic [W-2:0] gcd_value_i,
  input logic         bad_input_i
);

  // one item in flight: no intake while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while result pending");

  // after an item is taken, no second one next cycle
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("back-to-back intake");

  // bad input zeros the other fields
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && bad_input_i)
      |-> (coef_x_i == '0 && coef_y_i == '0 && gcd_value_i == '0))
    else $error("bad input with nonzero fields");

  // a good result has a positive gcd
  a_gcd_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !bad_input_i) |-> (gcd_value_i != '0))
    else $error("zero gcd on valid input");

  // result stays valid, with gcd and coef_x stable, until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i)
      |=> (out_valid_i && $stable(gcd_value_i) && $stable(coef_x_i)))
    else $error("result dropped under stall");

endmodule

bind signed_extended_gcd egcd_checker #(.W(WIDTH)) u_egcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .coef_x_i    (out_o.coef_x),
  .coef_y_i    (out_o.coef_y),
  .gcd_value_i (out_o.gcd_value),
  .bad_input_i (out_o.bad_input)
);

FILE: tb/signed_extended_gcd_test.sv
`timescale 1ns / 1ps
module signed_extended_gcd_test;
  localparam int W = 32;
  localparam int N_RANDOM = 400;
  localparam int WATCHDOG = 40000;
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [W-1:0] coef_x;
    logic [W-1:0] coef_y;
    logic [W-2:0] gcd_value;
    logic         bad_input;
  } bezout_t;

  typedef struct {
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic         known;
    bezout_t      res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  egcd_in_if  #(.W(W)) in_ch ();
  egcd_out_if #(.W(W)) out_ch ();

  signed_extended_gcd #(.WIDTH(W)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  bezout_t expected_q[$];
  int      mismatches = 0;
  int      results_seen = 0;
  int      bad_seen = 0;
  int      idle_cycles = 0;
  bit      calm = 1'b0;
  bit      hold_long = 1'b0;
  bit      sending_done = 1'b0;

  // Euclidean chain, coefficients kept modulo 2^W
  function automatic bezout_t solve_bezout(logic [W-1:0] xr, logic [W-1:0] yr);
    bezout_t       o;
    longint        x, y, r, p;
    longint        quots[$];
    logic [63:0]   a, b, a1;
    o = '0;
    if (yr == '0 || xr == MOST_NEG || yr == MOST_NEG) begin
      o.bad_input = 1'b1;
      return o;
    end
    x = longint'($signed(xr));
    y = longint'($signed(yr));
    forever begin
      r = x % y;
      p = x / y;
      if (r < 0) begin
        r += (y < 0) ? -y : y;
        p += (y > 0) ? -1 : 1;
      end
      if (r == 0) break;
      quots.push_back(p);
      x = y;
      y = r;
    end
    a = '0;
    b = (y < 0) ? '1 : 64'd1;
    while (quots.size() > 0) begin
      p = quots.pop_back();
      a1 = a;
      a = b;
      b = a1 - b * p;
    end
    o.coef_x = a[W-1:0];
    o.coef_y = b[W-1:0];
    o.gcd_value = (W-1)'((y < 0) ? (-y) : y);
    return o;
  endfunction

  // Operand side: send one item, with optional random gap before it
  task automatic send_operands(logic [W-1:0] x, logic [W-1:0] y, bit known, bezout_t res);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.x_value <= x;
    in_ch.y_value <= y;
    expected_q.push_back(known ? res : solve_bezout(x, y));
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  function automatic logic [W-1:0] rand_operand();
    logic [W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 20);
      1: v = -$urandom_range(0, 20);
      2: v = $urandom_range(0, 65535) * 12;
      3: v = {1'b1, (W-1)'($urandom_range(0, 31'h7fffffff))};
      default: v = $urandom();
    endcase
    if (v == MOST_NEG && $urandom_range(0, 1)) v = v + 1;
    return v;
  endfunction

  // Directed table
  stim_row_t rows[$];
  initial begin
    bezout_t bad;
    bezout_t zero_x;
    bad = '0;
    bad.bad_input = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.x_value = '0;
    in_ch.y_value = '0;
    zero_x = '0;
    zero_x.coef_y = W'(1);
    zero_x.gcd_value = (W-1)'(7);
    rows.push_back('{32'sd5, 32'sd0, 1'b1, bad});
    rows.push_back('{32'sd0, 32'sd0, 1'b1, bad});
    rows.push_back('{MOST_NEG, 32'sd3, 1'b1, bad});
    rows.push_back('{32'sd3, MOST_NEG, 1'b1, bad});
    rows.push_back('{32'sd0, 32'sd7, 1'b1, zero_x});
    zero_x.coef_y = '1;
    rows.push_back('{32'sd0, -32'sd7, 1'b1, zero_x});
    rows.push_back('{32'sh7fffffff, 32'sh7fffffff, 1'b0, bad});
    rows.push_back('{32'sh7fffffff, -32'sh7fffffff, 1'b0, bad});
    rows.push_back('{-32'sh7fffffff, 32'sh7ffffffe, 1'b0, bad});
    rows.push_back('{32'sd1, 32'sh7fffffff, 1'b0, bad});
    rows.push_back('{-32'sd1, -32'sd1, 1'b0, bad});
    rows.push_back('{32'sd240, 32'sd46, 1'b0, bad});
    rows.push_back('{-32'sd240, 32'sd46, 1'b0, bad});
    rows.push_back('{32'sd240, -32'sd46, 1'b0, bad});
    rows.push_back('{-32'sd240, -32'sd46, 1'b0, bad});
    rows.push_back('{32'sd1836311903, 32'sd1134903170, 1'b0, bad});
    rows.push_back('{-32'sd1134903170, 32'sd1836311903, 1'b0, bad});
    rows.push_back('{32'sd12, 32'sd4, 1'b0, bad});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_operands(rows[i].x, rows[i].y, rows[i].known, rows[i].res);
    in_ch.valid <= 1'b0;
    // pause until everything drained
    while (expected_q.size() != 0) @(posedge clk_i);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 100) hold_long = 1'b1;
      if (i == N_RANDOM - 60) calm = 1'b1;
      send_operands(rand_operand(), ($urandom_range(0, 30) == 0) ? '0 : rand_operand(),
                    1'b0, bad);
    end
    in_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Result side: random stalls plus one long hold-off
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_long = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Compare each result against the oldest expectation
  always @(posedge clk_i) begin
    bezout_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.coef_x, out_ch.coef_y, out_ch.gcd_value, out_ch.bad_input};
      results_seen++;
      if (got.bad_input) bad_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // Watchdog and end of run
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("signed_extended_gcd_test NOT OK");
      $finish;
    end
  end

  initial begin
    wait (sending_done);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    $display("covered %0d results (%0d bad input) incl. directed extremes,", results_seen,
             bad_seen);
    $display("long receiver hold-off and a full drain pause");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("signed_extended_gcd_test OK");
    end else begin
      $display("signed_extended_gcd_test NOT OK");
    end
    $finish;
  end
endmodule

FILE: sim.f
hdl/egcd_pkg.sv
hdl/egcd_if.sv
hdl/egcd_divider.sv
hdl/signed_extended_gcd.sv
hdl/egcd_checker.sv
tb/signed_extended_gcd_test.sv
